[design/lsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants, types and the arctangent table of the scan converter.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int INDEX_BITS    = 12;
  localparam int AIDX_W        = (INDEX_BITS < 12) ? INDEX_BITS : 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_COL_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_COL_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 3'd6;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // Item bookkeeping that rides along the pipeline.
  typedef struct packed {
    logic        ok;
    logic [11:0] idx;
    logic        last;
    logic [23:0] r;
    logic        flip;
  } meta_t;

  // Arctangent of 2^-i, 2^32 units per turn.
  function automatic logic signed [33:0] atan_turn32(input int i);
    logic signed [33:0] v;
    unique case (i)
      0: v = 34'sd536870912;   1: v = 34'sd316933406;   2: v = 34'sd167458907;
      3: v = 34'sd85004756;    4: v = 34'sd42667331;    5: v = 34'sd21354465;
      6: v = 34'sd10679838;    7: v = 34'sd5340245;     8: v = 34'sd2670163;
      9: v = 34'sd1335087;     10: v = 34'sd667544;     11: v = 34'sd333772;
      12: v = 34'sd166886;     13: v = 34'sd83443;      14: v = 34'sd41722;
      15: v = 34'sd20861;      16: v = 34'sd10430;      17: v = 34'sd5215;
      18: v = 34'sd2608;       19: v = 34'sd1304;       20: v = 34'sd652;
      21: v = 34'sd326;        22: v = 34'sd163;        23: v = 34'sd81;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

[design/lsc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_in_if / lsc_out_if
// Valid/ready channels carrying range readings and base-frame points.
// ----------------------------------------------------------------------------
interface lsc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] range_value;
  logic [11:0] beam_index;
  logic        scan_end;
  modport source (output valid, range_value, beam_index, scan_end, input ready);
  modport sink   (input valid, range_value, beam_index, scan_end, output ready);
endinterface

interface lsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               point_valid;
  logic [11:0]        point_index;
  logic               point_last;
  modport source (output valid, point_x, point_y, point_z, point_valid, point_index,
                  point_last, input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_valid, point_index,
                  point_last, output ready);
endinterface

[design/laser_scan_to_cartesian.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_scan_to_cartesian
// Converts a range reading and its beam index into a base-frame 3-D point.
// ----------------------------------------------------------------------------
// Channel  Direction  Content
// in_ch    sink       range_value, beam_index, scan_end
// out_ch   source     point_x/y/z, point_valid, point_index, point_last
// cfg_*    write      seven registers, index 0..6, no read-back
//
// One item is accepted per cycle while the output is not stalled; each item
// passes the angle, CORDIC rotation, multiply and saturate stages in turn.
// Reset (synchronous, active low) clears all valid bits and loads register
// defaults. A stall at the output freezes every stage together, so nothing
// is lost or repeated; the input is ready whenever the output register is
// empty or being taken.
module laser_scan_to_cartesian (
  input  logic                            clk,
  input  logic                            rst_n,
  lsc_in_if.sink                          in_ch,
  lsc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lsc_pkg::*;

  localparam int N = CORDIC_STAGES;

  // Configuration registers.
  logic [47:0] rot_col_x_r, rot_col_y_r, translation_r;
  logic [15:0] angle_start_r, angle_step_r;
  logic [23:0] range_low_r, range_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_col_x_r   <= 48'h4000;
      rot_col_y_r   <= 48'h4000_0000;
      translation_r <= '0;
      angle_start_r <= '0;
      angle_step_r  <= '0;
      range_low_r   <= '0;
      range_high_r  <= 24'hFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROT_COL_X:   rot_col_x_r   <= cfg_data;
        REG_ROT_COL_Y:   rot_col_y_r   <= cfg_data;
        REG_TRANSLATION: translation_r <= cfg_data;
        REG_ANGLE_START: angle_start_r <= cfg_data[15:0];
        REG_ANGLE_STEP:  angle_step_r  <= cfg_data[15:0];
        REG_RANGE_LOW:   range_low_r   <= cfg_data[23:0];
        REG_RANGE_HIGH:  range_high_r  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Global advance: all stages move together when the output can accept.
  logic adv;
  logic out_v_r;
  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 0: beam angle and range check.
  logic        s0_v_r;
  meta_t       s0_m_r;
  logic [15:0] s0_ang_r;
  logic [15:0] aidx;
  assign aidx = 16'(in_ch.beam_index[AIDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (adv) s0_v_r <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_m_r.ok   <= (in_ch.range_value >= range_low_r) &&
                     (in_ch.range_value <= range_high_r);
      s0_m_r.idx  <= in_ch.beam_index;
      s0_m_r.last <= in_ch.scan_end;
      s0_m_r.r    <= in_ch.range_value;
      s0_m_r.flip <= 1'b0;
      s0_ang_r    <= angle_start_r + 16'(aidx * angle_step_r);
    end
  end

  // CORDIC chain: entry 0 holds the folded start vector.
  logic              cv_r [N+1];
  meta_t             cm_r [N+1];
  logic signed [33:0] cx_r [N+1];
  logic signed [33:0] cy_r [N+1];
  logic signed [33:0] cz_r [N+1];

  logic        fold;
  logic [15:0] afold;
  meta_t       c0_m;
  assign fold  = s0_ang_r[15] ^ s0_ang_r[14];
  assign afold = {s0_ang_r[15] ^ fold, s0_ang_r[14:0]};

  // The item's bookkeeping picks up the half-turn flag here.
  always_comb begin
    c0_m      = s0_m_r;
    c0_m.flip = fold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else if (adv) cv_r[0] <= s0_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cm_r[0]      <= c0_m;
      cx_r[0]      <= CORDIC_GAIN_Q30;
      cy_r[0]      <= '0;
      cz_r[0]      <= {{2{afold[15]}}, afold, 16'h0000};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cordic
    logic signed [33:0] dx, dy;
    assign dx = cy_r[k] >>> k;
    assign dy = cx_r[k] >>> k;
    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[k+1] <= 1'b0;
      else if (adv) cv_r[k+1] <= cv_r[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cm_r[k+1] <= cm_r[k];
        if (!cz_r[k][33]) begin
          cx_r[k+1] <= cx_r[k] - dx;
          cy_r[k+1] <= cy_r[k] + dy;
          cz_r[k+1] <= cz_r[k] - atan_turn32(k);
        end else begin
          cx_r[k+1] <= cx_r[k] + dx;
          cy_r[k+1] <= cy_r[k] - dy;
          cz_r[k+1] <= cz_r[k] + atan_turn32(k);
        end
      end
    end
  end

  // M1: range times cosine and sine.
  logic               m1_v_r;
  meta_t              m1_m_r;
  logic signed [56:0] m1_pc_r, m1_ps_r;
  logic signed [31:0] cos_v, sin_v;
  logic signed [24:0] r_s;
  assign cos_v = cm_r[N].flip ? 32'(-cx_r[N]) : 32'(cx_r[N]);
  assign sin_v = cm_r[N].flip ? 32'(-cy_r[N]) : 32'(cy_r[N]);
  assign r_s   = $signed({1'b0, cm_r[N].r});

  always_ff @(posedge clk) begin
    if (!rst_n) m1_v_r <= 1'b0;
    else if (adv) m1_v_r <= cv_r[N];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_m_r  <= cm_r[N];
      m1_pc_r <= r_s * cos_v;
      m1_ps_r <= r_s * sin_v;
    end
  end

  // M2: round to laser-frame coordinates.
  logic               m2_v_r;
  meta_t              m2_m_r;
  logic signed [25:0] m2_lx_r, m2_ly_r;
  localparam logic signed [56:0] HALF30 = 57'sd536870912;

  always_ff @(posedge clk) begin
    if (!rst_n) m2_v_r <= 1'b0;
    else if (adv) m2_v_r <= m1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m2_m_r  <= m1_m_r;
      m2_lx_r <= 26'((m1_pc_r + HALF30) >>> 30);
      m2_ly_r <= 26'((m1_ps_r + HALF30) >>> 30);
    end
  end

  // M3: six rotation products, lane j is the output axis.
  logic               m3_v_r;
  meta_t              m3_m_r;
  logic signed [41:0] m3_pa_r [3];
  logic signed [41:0] m3_pb_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) m3_v_r <= 1'b0;
    else if (adv) m3_v_r <= m2_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) m3_m_r <= m2_m_r;
  end

  // M4: round, shift and add the translation.
  logic               m4_v_r;
  meta_t              m4_m_r;
  logic signed [33:0] m4_sum_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) m4_v_r <= 1'b0;
    else if (adv) m4_v_r <= m3_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) m4_m_r <= m3_m_r;
  end

  // Output register with saturation; an out-of-range reading gives zero.
  logic signed [31:0] out_p_r [3];
  meta_t              out_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= m4_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) out_m_r <= m4_m_r;
  end

  for (genvar j = 0; j < 3; j++) begin : g_axis
    logic signed [15:0] ra, rb, tv;
    logic signed [42:0] acc;
    logic signed [28:0] sh;
    logic signed [31:0] sat;
    assign ra  = $signed(rot_col_x_r[16*j +: 16]);
    assign rb  = $signed(rot_col_y_r[16*j +: 16]);
    assign tv  = $signed(translation_r[16*j +: 16]);
    assign acc = 43'(m3_pa_r[j]) + 43'(m3_pb_r[j]) + 43'sd8192;
    assign sh  = 29'(acc >>> 14);
    always_comb begin
      if (m4_sum_r[j][33:31] == 3'b000 || m4_sum_r[j][33:31] == 3'b111) begin
        sat = 32'(m4_sum_r[j]);
      end else if (m4_sum_r[j][33]) begin
        sat = 32'sh8000_0000;
      end else begin
        sat = 32'sh7FFF_FFFF;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        m3_pa_r[j]  <= ra * m2_lx_r;
        m3_pb_r[j]  <= rb * m2_ly_r;
        m4_sum_r[j] <= 34'(sh) + 34'(tv);
        out_p_r[j]  <= m4_m_r.ok ? sat : 32'sd0;
      end
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.point_x     = out_p_r[0];
  assign out_ch.point_y     = out_p_r[1];
  assign out_ch.point_z     = out_p_r[2];
  assign out_ch.point_valid = out_m_r.ok;
  assign out_ch.point_index = out_m_r.idx;
  assign out_ch.point_last  = out_m_r.last;

`ifndef SYNTH
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready does not follow output stall");

  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.point_valid) |->
    (out_ch.point_x == 0 && out_ch.point_y == 0 && out_ch.point_z == 0))
    else $error("rejected reading produced a nonzero point");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(m4_v_r) && $stable(m1_v_r)))
    else $error("pipeline moved during a stall");
`endif

endmodule
